// File: sv/pmq_pkg.sv
// Shared codes for the partitioned multi-queue block.
`default_nettype none

package pmq_pkg;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  localparam int unsigned QueueIndexWidth = 4;
  localparam int unsigned QueueCountWidth = 5;
  localparam int unsigned ItemWidth       = 32;

endpackage

`default_nettype wire

// File: sv/partitioned_multi_queue.sv
// Several linear queues sharing one slot store, split into equal segments.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o   op_i, queue_index_i, item_value_i
//   out      source     out_valid_o / out_stall_i status_o, data_out_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_data_i (queue count)
//
// One beat per cycle while the result side is not stalled: the pointer update, the store write and the
// store read all happen at the edge that takes a beat, and the result register loads there.
// The store has a single read port, which feeds the result register.
// Reset clears all pointers and sets the queue count to one; the store is not cleared.
// A stalled result holds the register and stalls the input side until taken.
// A configuration write empties every queue in the same edge.
`default_nettype none

module partitioned_multi_queue #(
  parameter int unsigned TOTAL_SLOTS = 32,
  parameter int unsigned MAX_QUEUES  = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  pmq_pkg::op_e                                op_i,
  input  logic [pmq_pkg::QueueIndexWidth-1:0]         queue_index_i,
  input  logic signed [pmq_pkg::ItemWidth-1:0]        item_value_i,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output pmq_pkg::status_e                            status_o,
  output logic signed [pmq_pkg::ItemWidth-1:0]        data_out_o,
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [pmq_pkg::QueueCountWidth-1:0]         cfg_data_i
);
  import pmq_pkg::*;

  localparam int unsigned CountLimit = (1 << QueueCountWidth) - 1;
  localparam int unsigned CntMaxA    = (MAX_QUEUES < CountLimit) ? MAX_QUEUES : CountLimit;
  localparam int unsigned CntMax     = (CntMaxA < TOTAL_SLOTS) ? CntMaxA : TOTAL_SLOTS;
  localparam int unsigned CntIdxW    = (CntMax > 1) ? $clog2(CntMax) : 1;
  localparam int unsigned QIndexMax  = 1 << QueueIndexWidth;
  localparam int unsigned QDepth     = (CntMax < QIndexMax) ? CntMax : QIndexMax;
  localparam int unsigned QIdxW      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned PtrW       = $clog2(TOTAL_SLOTS + 1);
  localparam int unsigned AddrW      = $clog2(TOTAL_SLOTS);
  localparam int unsigned SlotW      = PtrW + QueueIndexWidth;

  // segment size for each queue count, worked out at elaboration
  logic [PtrW-1:0] seg_tab [CntMax];
  for (genvar g = 0; g < CntMax; g++) begin : g_seg
    localparam int unsigned SegG = TOTAL_SLOTS / (g + 1);
    assign seg_tab[g] = PtrW'(SegG);
  end

  logic [QueueCountWidth-1:0] count_q, count_d;
  logic [PtrW-1:0]            seg_q, seg_d;
  logic [PtrW-1:0]            head_q [QDepth];
  logic [PtrW-1:0]            tail_q [QDepth];
  logic [DATA_WIDTH-1:0]      store_q [TOTAL_SLOTS];
  logic [DATA_WIDTH-1:0]      rd_data_q;
  logic                       rd_ok_q;
  logic                       out_valid_q;
  status_e                    status_q;

  logic                       in_take;
  logic                       cfg_take;
  logic [QIdxW-1:0]           qi;
  logic [PtrW-1:0]            head_cur, tail_cur, head_inc;
  logic [SlotW-1:0]           base, slot;
  logic [AddrW-1:0]           addr;
  logic                       in_range;
  logic                       do_write, do_read;
  status_e                    status_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_take    = cfg_valid_i;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_take     = in_valid_i && !in_stall_o;

  // effective count: zero acts as one, large values saturate
  always_comb begin
    count_d = cfg_data_i;
    if (cfg_data_i == '0) begin
      count_d = QueueCountWidth'(1);
    end else if (32'(cfg_data_i) > CntMax) begin
      count_d = QueueCountWidth'(CntMax);
    end
    seg_d = seg_tab[CntIdxW'(count_d - QueueCountWidth'(1))];
  end

  assign in_range = {1'b0, queue_index_i} < count_q;
  assign qi       = queue_index_i[QIdxW-1:0];
  assign head_cur = head_q[qi];
  assign tail_cur = tail_q[qi];
  assign head_inc = head_cur + PtrW'(1);
  assign base     = SlotW'(queue_index_i) * SlotW'(seg_q);

  always_comb begin
    status_d = ST_OK;
    do_write = 1'b0;
    do_read  = 1'b0;
    slot     = base + SlotW'(tail_cur);
    if (!in_range) begin
      status_d = ST_RANGE;
    end else if (op_i == OP_INSERT) begin
      if (tail_cur >= seg_q) begin
        status_d = ST_FULL;
      end else begin
        do_write = 1'b1;
      end
    end else begin
      slot = base + SlotW'(head_cur);
      if (tail_cur == '0) begin
        status_d = ST_EMPTY;
      end else begin
        do_read = 1'b1;
      end
    end
  end

  assign addr = slot[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= QueueCountWidth'(1);
      seg_q   <= PtrW'(TOTAL_SLOTS);
      for (int i = 0; i < QDepth; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else if (cfg_take) begin
      // new partitioning: drop every queue
      count_q <= count_d;
      seg_q   <= seg_d;
      for (int i = 0; i < QDepth; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else if (in_take) begin
      if (do_write) begin
        tail_q[qi] <= tail_cur + PtrW'(1);
      end else if (do_read) begin
        // drained: rewind both offsets to the segment base
        if (head_inc >= tail_cur) begin
          head_q[qi] <= '0;
          tail_q[qi] <= '0;
        end else begin
          head_q[qi] <= head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && do_write) begin
      store_q[addr] <= DATA_WIDTH'($unsigned(item_value_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && do_read) begin
      rd_data_q <= store_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
      status_q    <= ST_OK;
    end else if (!in_stall_o) begin
      out_valid_q <= in_take;
      if (in_take) begin
        rd_ok_q  <= do_read;
        status_q <= status_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = rd_ok_q ? $signed(ItemWidth'(rd_data_q)) : '0;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the partitioned multi-queue block.
`default_nettype none

module testbench;
  import pmq_pkg::*;

  localparam int TotalSlots = 32;
  localparam int MaxQueues  = 16;
  localparam int CycleLimit = 200000;
  localparam int RandomOps  = 800;

  typedef struct packed {
    status_e     status;
    logic [31:0] data;
  } result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  op_e                  op_i          = OP_INSERT;
  logic [3:0]           queue_index_i = '0;
  logic signed [31:0]   item_value_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  status_e              status_o;
  logic signed [31:0]   data_out_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [4:0]           cfg_data_i    = '0;

  partitioned_multi_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .queue_index_i (queue_index_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the queue state
  logic [4:0]  queue_count_q;
  int          head_q [MaxQueues];
  int          tail_q [MaxQueues];
  logic [31:0] slot_mem [TotalSlots];

  result_t pending_results[$];
  int      errors       = 0;
  int      ops_sent     = 0;
  int      cfg_writes   = 0;
  int      status_seen [4];
  int      burst_left   = 0;
  int      cycles       = 0;
  int      stall_mode   = 0;
  int      stall_hold   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int live_queues();
    int n;
    n = queue_count_q;
    if (n == 0) n = 1;
    if (n > MaxQueues) n = MaxQueues;
    if (n > TotalSlots) n = TotalSlots;
    return n;
  endfunction

  function automatic void empty_all_queues();
    for (int i = 0; i < MaxQueues; i++) begin
      head_q[i] = 0;
      tail_q[i] = 0;
    end
  endfunction

  function automatic result_t apply_queue_op(op_e op, logic [3:0] q, logic [31:0] val);
    int n;
    int seg;
    result_t r;
    n = live_queues();
    seg = TotalSlots / n;
    r.status = ST_OK;
    r.data = '0;
    if (int'(q) >= n) begin
      r.status = ST_RANGE;
    end else if (op == OP_INSERT) begin
      if (tail_q[q] >= seg) begin
        r.status = ST_FULL;
      end else begin
        slot_mem[q * seg + tail_q[q]] = val;
        tail_q[q]++;
      end
    end else begin
      if (tail_q[q] == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.data = slot_mem[q * seg + head_q[q]];
        head_q[q]++;
        // linear queue: rewind only once drained
        if (head_q[q] >= tail_q[q]) begin
          head_q[q] = 0;
          tail_q[q] = 0;
        end
      end
    end
    return r;
  endfunction

  task automatic send_op(input op_e op, input logic [3:0] q, input logic [31:0] val);
    int   gap;
    logic stalled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    op_i          <= op;
    queue_index_i <= q;
    item_value_i  <= val;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    pending_results.push_back(apply_queue_op(op, q, val));
    ops_sent++;
  endtask

  // Write only once the block has drained every result
  task automatic set_queue_count(input logic [4:0] count);
    logic ready;
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do begin
      @(negedge clk_i);
      ready = cfg_ready_o;
      @(posedge clk_i);
    end while (!ready);
    cfg_valid_i <= 1'b0;
    queue_count_q = count;
    empty_all_queues();
    cfg_writes++;
  endtask

  task automatic test_reset_defaults();
    send_op(OP_REMOVE, 4'd0, 32'h0);
    send_op(OP_INSERT, 4'd1, 32'h1234_5678);
    send_op(OP_REMOVE, 4'd15, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 4'd0, 32'hA5A5_5A5A);
    send_op(OP_REMOVE, 4'd0, 32'h0);
  endtask

  task automatic test_segment_limits();
    // sixteen queues of two slots: full after a remove, then drain and reuse
    set_queue_count(5'd16);
    send_op(OP_INSERT, 4'd15, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 4'd15, 32'h8000_0000);
    send_op(OP_INSERT, 4'd15, 32'hDEAD_BEEF);
    send_op(OP_REMOVE, 4'd15, 32'h0);
    send_op(OP_INSERT, 4'd15, 32'hCAFE_F00D);
    send_op(OP_REMOVE, 4'd15, 32'hFFFF_FFFF);
    send_op(OP_REMOVE, 4'd15, 32'h0);
    send_op(OP_INSERT, 4'd15, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 4'd0, 32'h0000_0000);
    send_op(OP_REMOVE, 4'd0, 32'h0);
    send_op(OP_REMOVE, 4'd15, 32'h0);
  endtask

  task automatic test_count_saturation();
    set_queue_count(5'd0);
    send_op(OP_INSERT, 4'd1, 32'h1111_1111);
    send_op(OP_INSERT, 4'd0, 32'h0000_0001);
    send_op(OP_REMOVE, 4'd0, 32'h0);
    set_queue_count(5'd31);
    send_op(OP_INSERT, 4'd15, 32'h5555_AAAA);
    send_op(OP_REMOVE, 4'd15, 32'h0);
    set_queue_count(5'd3);
    send_op(OP_INSERT, 4'd3, 32'h0F0F_0F0F);
    send_op(OP_REMOVE, 4'd2, 32'h0);
  endtask

  task automatic test_random_traffic();
    logic [4:0] counts [10];
    int         per_phase;
    int         n;
    int         hot;
    int         insert_pct;
    int         pick;
    logic [3:0] q;
    logic [31:0] val;
    op_e        op;
    counts = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd5, 5'd0, 5'd8, 5'd2, 5'd13, 5'd7};
    per_phase = RandomOps / 12;
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 10) set_queue_count(counts[ph]);
      else set_queue_count(5'($urandom_range(0, 31)));
      n = live_queues();
      hot = 0;
      insert_pct = 50;
      for (int i = 0; i < per_phase; i++) begin
        if (i % 16 == 0) begin
          hot = $urandom_range(0, n - 1);
          case ($urandom_range(0, 3))
            0: insert_pct = 25;
            1: insert_pct = 50;
            2: insert_pct = 75;
            default: insert_pct = 90;
          endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) q = 4'(hot);
        else if (pick < 88) q = 4'($urandom_range(0, n - 1));
        else q = 4'($urandom_range(0, 15));
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        case ($urandom_range(0, 9))
          0: val = 32'h7FFF_FFFF;
          1: val = 32'h8000_0000;
          default: val = $urandom;
        endcase
        send_op(op, q, val);
      end
    end
  endtask

  // Receiver stall pattern: free-running, light random, or held runs
  always @(posedge clk_i) begin
    if (cycles % 128 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_hold > 0) begin
          stall_hold--;
          out_stall_i <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
          stall_hold = $urandom_range(1, 8);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Values seen at the falling edge hold until the next rising edge
  always @(negedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      status_seen[status_o]++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d data %h", status_o, data_out_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (data_out_o !== want.data) begin
          $error("data_out: expected %h, got %h", want.data, data_out_o);
          errors++;
        end
      end
    end
  end

  initial begin
    queue_count_q = 5'd1;
    empty_all_queues();
    for (int i = 0; i < TotalSlots; i++) slot_mem[i] = '0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_segment_limits();
    test_count_saturation();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("%0d queue operations over %0d queue-count settings", ops_sent, cfg_writes);
    $display("results: %0d ok, %0d full, %0d empty, %0d out of range",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
